### design/lkv_pkg.sv
`default_nettype none

package lkv_pkg;

   // Default store depth and reset capacity
   localparam int unsigned MAX_ENTRIES_DEF = 16;
   localparam logic [4:0]  CAP_RESET       = 5'd16;

   // Request opcodes
   localparam logic OP_GET = 1'b0;
   localparam logic OP_PUT = 1'b1;

   // Value returned by a get that misses
   localparam logic [31:0] MISS_VALUE = 32'hFFFF_FFFF;

   // Write strobes into the entry store
   typedef struct packed {
      logic key_en;
      logic value_en;
      logic rank_en;
   } lkv_wr_type;

endpackage

`default_nettype wire

### design/lru_key_value_cache.sv
// A get miss returns after the scan pass; a hit or put runs a scan pass and then a rank
//   update pass. A new request is accepted only in idle, after the previous response is
//   registered. Both passes step one entry per cycle through the single read port of the
//   entry store, and a response still held stalls.
// Reset (synchronous, active high): store empty, capacity 16, no response pending;
//   the store memories are not cleared, the fill count marks the valid slots.
`default_nettype none

module lru_key_value_cache #(
   parameter int unsigned MAX_ENTRIES = lkv_pkg::MAX_ENTRIES_DEF
) (
   input  wire         clock,
   input  wire         reset,
   // request channel
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [63:0] req_tdata,   // [31:0] lookup_key, [63:32] write_value
   input  wire  [0:0]  req_tuser,   // [0] opcode
   // response channel
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] read_value
   output logic [1:0]  rsp_tuser,   // [0] hit, [1] evicted
   // capacity register
   input  wire         csr_we,
   input  wire  [4:0]  csr_wdata
);
   import lkv_pkg::*;

   localparam int unsigned IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);

   // Sequencer states
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_UPD  = 2'd2;
   localparam logic [1:0] ST_RESP = 2'd3;

   logic [1:0]    state_ff, state_in;
   logic [4:0]    cap_ff;
   logic [CW-1:0] occ_ff, occ_in;
   logic [CW-1:0] ptr_ff, ptr_in;
   logic          pend_ff, pend_in;
   logic [IW-1:0] pidx_ff, pidx_in;

   // captured request
   logic          op_ff, op_in;
   logic [31:0]   key_ff, key_in;
   logic [31:0]   val_ff, val_in;

   // scan results
   logic          hit_ff, hit_in;
   logic [IW-1:0] tgt_ff, tgt_in;
   logic [IW-1:0] thr_ff, thr_in;
   logic [IW-1:0] vict_ff, vict_in;
   logic [31:0]   hval_ff, hval_in;
   logic          free_ff, free_in;

   // response
   logic          res_hit_ff, res_hit_in;
   logic [31:0]   res_value_ff, res_value_in;
   logic          res_evict_ff, res_evict_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_hit_ff, rsp_hit_in;
   logic [31:0]   rsp_value_ff, rsp_value_in;
   logic          rsp_evict_ff, rsp_evict_in;

   // store interface
   lkv_wr_type    wr_ctl;
   logic [IW-1:0] kv_waddr;
   logic [IW-1:0] rank_waddr;
   logic [IW-1:0] wrank;
   logic [IW-1:0] raddr;
   logic [31:0]   rkey;
   logic [31:0]   rvalue;
   logic [IW-1:0] rrank;

   logic [CW-1:0] eff_cap;
   logic [IW-1:0] last_rank;
   logic          issue;
   logic          pass_done;
   logic          room;

   lkv_store #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_store (
      .clock      (clock),
      .wr_ctl     (wr_ctl),
      .kv_waddr   (kv_waddr),
      .wkey       (key_ff),
      .wvalue     (val_ff),
      .rank_waddr (rank_waddr),
      .wrank      (wrank),
      .raddr      (raddr),
      .rkey       (rkey),
      .rvalue     (rvalue),
      .rrank      (rrank)
   );

   function automatic logic csr_cap_zero();
      return (cap_ff == 5'd0);
   endfunction

   // Clamp the capacity register into 1 .. MAX_ENTRIES
   always_comb begin
      priority if (csr_cap_zero()) begin
         eff_cap = CW'(1);
      end else if (32'(cap_ff) > 32'(MAX_ENTRIES)) begin
         eff_cap = CW'(MAX_ENTRIES);
      end else begin
         eff_cap = CW'(cap_ff);
      end
   end

   // The valid slots are always 0 .. occ-1, so the oldest rank is occ-1
   assign last_rank = IW'(occ_ff - CW'(1));
   assign room      = (occ_ff < eff_cap) && (occ_ff < CW'(MAX_ENTRIES));
   assign issue     = ((state_ff == ST_SCAN) || (state_ff == ST_UPD)) && (ptr_ff < occ_ff);
   assign pass_done = (ptr_ff >= occ_ff) && !pend_ff;
   assign raddr     = ptr_ff[IW-1:0];

   always_comb begin
      state_in     = state_ff;
      occ_in       = occ_ff;
      ptr_in       = ptr_ff;
      pend_in      = 1'b0;
      pidx_in      = pidx_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      val_in       = val_ff;
      hit_in       = hit_ff;
      tgt_in       = tgt_ff;
      thr_in       = thr_ff;
      vict_in      = vict_ff;
      hval_in      = hval_ff;
      free_in      = free_ff;
      res_hit_in   = res_hit_ff;
      res_value_in = res_value_ff;
      res_evict_in = res_evict_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_value_in = rsp_value_ff;
      rsp_evict_in = rsp_evict_ff;
      wr_ctl       = '0;
      kv_waddr     = tgt_ff;
      rank_waddr   = pidx_ff;
      wrank        = '0;
      req_tready   = 1'b0;

      // Drop the response once taken
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      // Advance the read pointer of either pass
      if (issue) begin
         ptr_in  = ptr_ff + CW'(1);
         pend_in = 1'b1;
         pidx_in = ptr_ff[IW-1:0];
      end

      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               op_in    = req_tuser[0];
               key_in   = req_tdata[31:0];
               val_in   = req_tdata[63:32];
               hit_in   = 1'b0;
               ptr_in   = '0;
               state_in = ST_SCAN;
            end
         end

         ST_SCAN: begin
            // Compare the returned entry against the request key
            if (pend_ff) begin
               if (rkey == key_ff) begin
                  hit_in  = 1'b1;
                  tgt_in  = pidx_ff;
                  thr_in  = rrank;
                  hval_in = rvalue;
               end
               if (rrank == last_rank) begin
                  vict_in = pidx_ff;
               end
            end
            if (pass_done) begin
               ptr_in       = '0;
               res_hit_in   = hit_ff;
               res_value_in = '0;
               res_evict_in = 1'b0;
               free_in      = 1'b0;
               state_in     = ST_UPD;
               if (op_ff == OP_GET) begin
                  res_value_in = hit_ff ? hval_ff : MISS_VALUE;
                  if (!hit_ff) begin
                     state_in = ST_RESP;
                  end
               end else if (hit_ff) begin
                  // Overwrite the value in place
                  wr_ctl.value_en = 1'b1;
                  kv_waddr        = tgt_ff;
               end else if (room) begin
                  // Fill the next free slot as most recent, age every other entry
                  wr_ctl.key_en   = 1'b1;
                  wr_ctl.value_en = 1'b1;
                  wr_ctl.rank_en  = 1'b1;
                  kv_waddr        = occ_ff[IW-1:0];
                  rank_waddr      = occ_ff[IW-1:0];
                  wrank           = '0;
                  free_in         = 1'b1;
                  thr_in          = occ_ff[IW-1:0];
               end else begin
                  // Replace the oldest entry
                  wr_ctl.key_en   = 1'b1;
                  wr_ctl.value_en = 1'b1;
                  kv_waddr        = vict_ff;
                  tgt_in          = vict_ff;
                  thr_in          = last_rank;
                  res_evict_in    = 1'b1;
               end
            end
         end

         ST_UPD: begin
            // Rewrite each rank: target goes to zero, younger entries age by one; a fill ages all
            if (pend_ff) begin
               wr_ctl.rank_en = 1'b1;
               rank_waddr     = pidx_ff;
               if (!free_ff && (pidx_ff == tgt_ff)) begin
                  wrank = '0;
               end else if (rrank < thr_ff) begin
                  wrank = rrank + IW'(1);
               end else begin
                  wrank = rrank;
               end
            end
            if (pass_done) begin
               if (free_ff) begin
                  occ_in = occ_ff + CW'(1);
               end
               state_in = ST_RESP;
            end
         end

         ST_RESP: begin
            // Hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = res_hit_ff;
               rsp_value_in = res_value_ff;
               rsp_evict_in = res_evict_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cap_ff       <= CAP_RESET;
         occ_ff       <= '0;
         ptr_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         ptr_ff       <= ptr_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            cap_ff <= csr_wdata;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      pidx_ff      <= pidx_in;
      op_ff        <= op_in;
      key_ff       <= key_in;
      val_ff       <= val_in;
      hit_ff       <= hit_in;
      tgt_ff       <= tgt_in;
      thr_ff       <= thr_in;
      vict_ff      <= vict_in;
      hval_ff      <= hval_in;
      free_ff      <= free_in;
      res_hit_ff   <= res_hit_in;
      res_value_ff <= res_value_in;
      res_evict_ff <= res_evict_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_value_ff <= rsp_value_in;
      rsp_evict_ff <= rsp_evict_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = {rsp_evict_ff, rsp_hit_ff};

   // Occupancy never passes the store depth
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      32'(occ_ff) <= 32'(MAX_ENTRIES))
      else $error("occupancy above store depth");

   // Occupancy only ever grows by one
   a_occ_step: assert property (@(posedge clock) disable iff (reset)
      (occ_ff != $past(occ_ff)) |-> (occ_ff == $past(occ_ff) + CW'(1)))
      else $error("occupancy changed by more than one");

   // The read pointer stays within the filled slots
   a_ptr_bound: assert property (@(posedge clock) disable iff (reset)
      ptr_ff <= occ_ff)
      else $error("read pointer beyond occupancy");

   // An eviction is never a hit and needs a filled store
   a_evict: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_evict_ff) |-> (!rsp_hit_ff && (occ_ff != '0)))
      else $error("bad eviction response");

endmodule

`default_nettype wire

### design/lkv_store.sv
`default_nettype none

module lkv_store #(
   parameter int unsigned MAX_ENTRIES = lkv_pkg::MAX_ENTRIES_DEF,
   localparam int unsigned IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
   input  wire                     clock,
   input  lkv_pkg::lkv_wr_type     wr_ctl,
   input  wire  [IW-1:0]           kv_waddr,
   input  wire  [31:0]             wkey,
   input  wire  [31:0]             wvalue,
   input  wire  [IW-1:0]           rank_waddr,
   input  wire  [IW-1:0]           wrank,
   input  wire  [IW-1:0]           raddr,
   output logic [31:0]             rkey,
   output logic [31:0]             rvalue,
   output logic [IW-1:0]           rrank
);
   import lkv_pkg::*;

   logic [31:0]   key_mem   [MAX_ENTRIES];
   logic [31:0]   value_mem [MAX_ENTRIES];
   logic [IW-1:0] rank_mem  [MAX_ENTRIES];

   // Write ports
   always_ff @(posedge clock) begin
      if (wr_ctl.key_en) begin
         key_mem[kv_waddr] <= wkey;
      end
      if (wr_ctl.value_en) begin
         value_mem[kv_waddr] <= wvalue;
      end
      if (wr_ctl.rank_en) begin
         rank_mem[rank_waddr] <= wrank;
      end
   end

   // Registered read port, one address for all three arrays
   always_ff @(posedge clock) begin
      rkey   <= key_mem[raddr];
      rvalue <= value_mem[raddr];
      rrank  <= rank_mem[raddr];
   end

endmodule

`default_nettype wire

### tb/sv/tb.sv
typedef struct packed {
   logic        hit;
   logic [31:0] read_value;
   logic        evicted;
} cache_result_type;

class lru_scoreboard;
   localparam int DEPTH = lkv_pkg::MAX_ENTRIES_DEF;

   logic [31:0]      slot_key   [DEPTH];
   logic [31:0]      slot_value [DEPTH];
   bit               slot_valid [DEPTH];
   int unsigned      slot_rank  [DEPTH];
   int unsigned      fill_count;
   logic [4:0]       capacity_reg;
   cache_result_type pending_results[$];
   int               mismatches;
   int               requests_seen;
   int               hits_seen;
   int               evictions_seen;

   function new();
      for (int i = 0; i < DEPTH; i++) begin
         slot_key[i]   = '0;
         slot_value[i] = '0;
         slot_valid[i] = 0;
         slot_rank[i]  = 0;
      end
      fill_count     = 0;
      capacity_reg   = lkv_pkg::CAP_RESET;
      mismatches     = 0;
      requests_seen  = 0;
      hits_seen      = 0;
      evictions_seen = 0;
   endfunction

   function void set_capacity(logic [4:0] value);
      capacity_reg = value;
   endfunction

   function int pending_count();
      return pending_results.size();
   endfunction

   // move a slot to rank 0, aging only the entries that were younger
   function void promote(int slot);
      int unsigned old_rank;
      old_rank = slot_rank[slot];
      for (int i = 0; i < DEPTH; i++)
         if (slot_valid[i] && i != slot && slot_rank[i] < old_rank)
            slot_rank[i]++;
      slot_rank[slot] = 0;
   endfunction

   function void note_request(logic opcode, logic [31:0] key, logic [31:0] value);
      int               slot;
      int               victim;
      int unsigned      limit;
      cache_result_type res;
      slot = -1;
      for (int i = 0; i < DEPTH; i++)
         if (slot_valid[i] && slot_key[i] == key) begin
            slot = i;
            break;
         end
      res.hit        = (slot >= 0);
      res.read_value = '0;
      res.evicted    = 1'b0;
      if (opcode == lkv_pkg::OP_GET) begin
         if (slot >= 0) begin
            res.read_value = slot_value[slot];
            promote(slot);
         end else begin
            res.read_value = lkv_pkg::MISS_VALUE;
         end
      end else if (slot >= 0) begin
         slot_value[slot] = value;
         promote(slot);
      end else begin
         limit = (capacity_reg == 0) ? 1 : int'(capacity_reg);
         if (limit > DEPTH)
            limit = DEPTH;
         if (fill_count < limit) begin
            slot = -1;
            for (int i = 0; i < DEPTH; i++)
               if (!slot_valid[i]) begin
                  slot = i;
                  break;
               end
            for (int i = 0; i < DEPTH; i++)
               if (slot_valid[i])
                  slot_rank[i]++;
            slot_valid[slot] = 1;
            slot_key[slot]   = key;
            slot_value[slot] = value;
            slot_rank[slot]  = 0;
            fill_count++;
         end else begin
            victim = -1;
            for (int i = 0; i < DEPTH; i++)
               if (slot_valid[i] && (victim < 0 || slot_rank[i] > slot_rank[victim]))
                  victim = i;
            slot_key[victim]   = key;
            slot_value[victim] = value;
            promote(victim);
            res.evicted = 1'b1;
         end
      end
      requests_seen++;
      if (res.hit)
         hits_seen++;
      if (res.evicted)
         evictions_seen++;
      pending_results.push_back(res);
   endfunction

   task report_mismatch(string what);
      $display("MISMATCH: %s", what);
      mismatches++;
   endtask

   task check_response(logic hit, logic [31:0] read_value, logic evicted);
      cache_result_type want;
      if (pending_results.size() == 0) begin
         report_mismatch("response with no request outstanding");
      end else begin
         want = pending_results.pop_front();
         if (hit !== want.hit)
            report_mismatch($sformatf("hit %b, want %b", hit, want.hit));
         if (read_value !== want.read_value)
            report_mismatch($sformatf("read_value %h, want %h", read_value,
                                      want.read_value));
         if (evicted !== want.evicted)
            report_mismatch($sformatf("evicted %b, want %b", evicted, want.evicted));
      end
   endtask
endclass

module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import lkv_pkg::*;

   localparam int CLOCK_PERIOD  = 12;
   localparam int RESET_CYCLES  = 11;
   localparam int MAX_GAP       = 18;
   localparam int PHASE_ITEMS   = 90;
   localparam int POOL_SIZE     = 24;
   localparam int HOLD_CYCLES   = 400;
   // settle for longer than the worst request, a hit or put on a full store of 16
   localparam int SETTLE_CYCLES = 45;
   localparam int CYCLE_LIMIT   = 400000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;   // [31:0] lookup_key, [63:32] write_value
   logic [0:0]  req_tuser = '0;   // [0] opcode
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // [31:0] read_value
   logic [1:0]  rsp_tuser;        // [0] hit, [1] evicted
   logic        csr_we = 1'b0;
   logic [4:0]  csr_wdata = '0;

   lru_scoreboard cache_sb;
   logic [31:0]   key_pool[POOL_SIZE];
   bit            req_no_idle = 0;
   bit            hold_rsp_long = 0;
   int            cycle_count = 0;
   int            settings_used = 0;

   lru_key_value_cache dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Watchdog: abort the run if the block stops making progress.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("tb NOT OK");
         $finish;
      end
   end

   // Offer one request, idling a random number of cycles first. Valid is
   // lowered only when a gap follows, so back-to-back requests keep it high.
   task automatic send_request(input logic opcode, input logic [31:0] key,
                               input logic [31:0] value);
      int gap;
      gap = req_no_idle ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= opcode;
      req_tdata  <= {value, key};
      do @(posedge clock); while (!req_tready);
      cache_sb.note_request(opcode, key, value);
   endtask

   // Draw a request: mostly keys from a pool span at or up to four above the capacity,
   // so hits, misses and evictions all stay frequent; some fully random keys.
   task automatic send_random_request(input int span);
      logic        opcode;
      logic [31:0] key;
      logic [31:0] value;
      int          pick;
      opcode = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 4) == 0)
         key = $urandom;
      else
         key = key_pool[$urandom_range(0, span - 1)];
      pick = $urandom_range(0, 9);
      if (pick == 0)
         value = 32'h8000_0000;
      else if (pick == 1)
         value = 32'h7FFF_FFFF;
      else
         value = $urandom;
      send_request(opcode, key, value);
   endtask

   // Drop valid and wait until every outstanding response has come back.
   task automatic drain_requests();
      req_tvalid <= 1'b0;
      while (cache_sb.pending_count() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write the capacity register; only called while the block is idle.
   task automatic write_capacity(input logic [4:0] value);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      cache_sb.set_capacity(value);
      settings_used++;
      @(posedge clock);
   endtask

   // Response side: stall at random, with one long hold-off on request.
   initial begin : response_sink
      int gap;
      int taken;
      bit rsp_no_idle;
      taken = 0;
      rsp_no_idle = 0;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         if (hold_rsp_long) begin
            // hold ready low long enough for the request side to back up
            hold_rsp_long = 0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         gap = rsp_no_idle ? 0 : $urandom_range(0, MAX_GAP);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         cache_sb.check_response(rsp_tuser[0], rsp_tdata, rsp_tuser[1]);
         taken++;
         if (taken % 20 == 0)
            rsp_no_idle = ($urandom_range(0, 3) == 0);
      end
   end

   initial begin : stimulus
      logic [4:0] cap_plan[6];
      int         limit;
      int         span;
      cache_sb = new();
      for (int i = 0; i < POOL_SIZE; i++)
         key_pool[i] = $urandom;
      key_pool[0] = 32'h8000_0000;
      key_pool[1] = 32'h7FFF_FFFF;
      key_pool[2] = 32'hFFFF_FFFF;
      key_pool[3] = 32'h0000_0000;
      cap_plan[0] = 5'd1;
      cap_plan[1] = 5'd0;
      cap_plan[2] = 5'd31;
      cap_plan[3] = 5'd16;
      cap_plan[4] = 5'd7;
      cap_plan[5] = 5'($urandom_range(2, 15));

      // hold reset, then release it once
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part at reset capacity: empty store, extreme keys and values,
      // a stored value of -1 that must still read as a hit, an update.
      send_request(OP_GET, 32'h0000_0000, 32'h0000_0000);
      send_request(OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
      send_request(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
      send_request(OP_GET, 32'h8000_0000, 32'h0000_0000);
      send_request(OP_GET, 32'h7FFF_FFFF, 32'h0000_0000);
      send_request(OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
      send_request(OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
      send_request(OP_PUT, 32'h8000_0000, 32'h0000_0000);
      send_request(OP_PUT, 32'h0000_0000, 32'h0000_0000);
      send_request(OP_GET, 32'h8000_0000, 32'hFFFF_FFFF);
      drain_requests();

      // Capacity lowered below the fill count: new keys replace one entry each.
      write_capacity(5'd2);
      send_request(OP_PUT, 32'h1234_5678, 32'h0BAD_F00D);
      send_request(OP_PUT, 32'h2468_ACE0, 32'h1357_9BDF);
      send_request(OP_GET, 32'h7FFF_FFFF, 32'h0000_0000);
      send_request(OP_GET, 32'h1234_5678, 32'h0000_0000);
      drain_requests();

      // Capacity zero behaves as one.
      write_capacity(5'd0);
      send_request(OP_PUT, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
      send_request(OP_GET, 32'hA5A5_A5A5, 32'h0000_0000);
      send_request(OP_PUT, 32'h5A5A_5A5A, 32'hA5A5_A5A5);
      send_request(OP_GET, 32'hA5A5_A5A5, 32'h0000_0000);
      drain_requests();

      // Capacity above the store depth behaves as the depth.
      write_capacity(5'd31);
      for (int i = 0; i < 4; i++)
         send_request(OP_PUT, 32'h1111_1111 * (i + 1), 32'($urandom));
      drain_requests();

      // Random phases, one per capacity setting.
      for (int p = 0; p < 6; p++) begin
         write_capacity(cap_plan[p]);
         limit = (cap_plan[p] == 0) ? 1 : (cap_plan[p] > 16 ? 16 : int'(cap_plan[p]));
         span = limit + $urandom_range(0, 4);
         if (span > POOL_SIZE)
            span = POOL_SIZE;
         // full store at capacity 16: let the response side back up once
         if (p == 3)
            hold_rsp_long = 1;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n % 25 == 0)
               req_no_idle = ($urandom_range(0, 3) == 0);
            send_random_request(span);
         end
         drain_requests();
      end

      req_no_idle = 0;
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (cache_sb.pending_count() != 0)
         cache_sb.report_mismatch("responses still outstanding at end of run");

      $display("ran %0d requests across %0d capacity settings", cache_sb.requests_seen,
               settings_used + 1);
      $display("saw %0d hits and %0d evictions, %0d mismatches", cache_sb.hits_seen,
               cache_sb.evictions_seen, cache_sb.mismatches);
      if (cache_sb.mismatches == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end
endmodule
